// File: design/lmcf_pkg.sv
// ----------------------------------------------------------------------------
// lmcf_pkg
// Shared types, codes and font table of the LED matrix clock frame generator.
// ----------------------------------------------------------------------------
package lmcf_pkg;

    localparam logic [2:0] CMD_INIT   = 3'd0;
    localparam logic [2:0] CMD_BRIGHT = 3'd1;
    localparam logic [2:0] CMD_CLEAR  = 3'd2;
    localparam logic [2:0] CMD_TIME   = 3'd3;
    localparam logic [2:0] CMD_ZEROS  = 3'd4;
    localparam logic [2:0] CMD_PIXEL  = 3'd5;

    localparam logic [2:0] OP_INIT   = 3'd0;
    localparam logic [2:0] OP_BRIGHT = 3'd1;
    localparam logic [2:0] OP_CLEAR  = 3'd2;
    localparam logic [2:0] OP_DIGITS = 3'd3;
    localparam logic [2:0] OP_PIXEL  = 3'd4;

    localparam logic [3:0] GLYPH_COLON = 4'd10;

    localparam logic [3:0] ADDR_DECODE    = 4'h9;
    localparam logic [3:0] ADDR_INTENSITY = 4'hA;
    localparam logic [3:0] ADDR_SCAN      = 4'hB;
    localparam logic [3:0] ADDR_SHUTDOWN  = 4'hC;
    localparam logic [3:0] ADDR_TEST      = 4'hF;

    localparam logic [7:0] MAX_LEVEL = 8'd15;
    localparam logic [6:0] MAX_VALUE = 7'd99;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int unsigned FONT_COLS = 5;
    localparam logic [2:0]  LAST_COL  = 3'(FONT_COLS - 1);
    localparam logic [2:0]  LAST_MAT  = 3'd4;
    localparam logic [4:0]  MAX_STEP  = 5'd24;

    typedef struct packed {
        logic [2:0]      op;
        logic [3:0]      level;
        logic [4:0][3:0] glyph;
        logic [2:0]      matrix;
        logic [3:0]      column;
        logic [7:0]      pixel;
    } cmd_desc_t;

    function automatic logic [7:0] glyph_byte(input logic [3:0] code, input logic [2:0] col);
        logic [7:0] b;
        b = 8'h00;
        case ({code, col})
            {4'd0, 3'd0}: b = 8'h3E; {4'd0, 3'd1}: b = 8'h41; {4'd0, 3'd2}: b = 8'h41;
            {4'd0, 3'd3}: b = 8'h41; {4'd0, 3'd4}: b = 8'h3E;
            {4'd1, 3'd0}: b = 8'h00; {4'd1, 3'd1}: b = 8'h42; {4'd1, 3'd2}: b = 8'h7F;
            {4'd1, 3'd3}: b = 8'h40; {4'd1, 3'd4}: b = 8'h00;
            {4'd2, 3'd0}: b = 8'h62; {4'd2, 3'd1}: b = 8'h51; {4'd2, 3'd2}: b = 8'h49;
            {4'd2, 3'd3}: b = 8'h49; {4'd2, 3'd4}: b = 8'h46;
            {4'd3, 3'd0}: b = 8'h22; {4'd3, 3'd1}: b = 8'h41; {4'd3, 3'd2}: b = 8'h49;
            {4'd3, 3'd3}: b = 8'h49; {4'd3, 3'd4}: b = 8'h36;
            {4'd4, 3'd0}: b = 8'h18; {4'd4, 3'd1}: b = 8'h14; {4'd4, 3'd2}: b = 8'h12;
            {4'd4, 3'd3}: b = 8'h7F; {4'd4, 3'd4}: b = 8'h10;
            {4'd5, 3'd0}: b = 8'h2F; {4'd5, 3'd1}: b = 8'h49; {4'd5, 3'd2}: b = 8'h49;
            {4'd5, 3'd3}: b = 8'h49; {4'd5, 3'd4}: b = 8'h31;
            {4'd6, 3'd0}: b = 8'h3E; {4'd6, 3'd1}: b = 8'h49; {4'd6, 3'd2}: b = 8'h49;
            {4'd6, 3'd3}: b = 8'h49; {4'd6, 3'd4}: b = 8'h32;
            {4'd7, 3'd0}: b = 8'h01; {4'd7, 3'd1}: b = 8'h71; {4'd7, 3'd2}: b = 8'h09;
            {4'd7, 3'd3}: b = 8'h05; {4'd7, 3'd4}: b = 8'h03;
            {4'd8, 3'd0}: b = 8'h36; {4'd8, 3'd1}: b = 8'h49; {4'd8, 3'd2}: b = 8'h49;
            {4'd8, 3'd3}: b = 8'h49; {4'd8, 3'd4}: b = 8'h36;
            {4'd9, 3'd0}: b = 8'h26; {4'd9, 3'd1}: b = 8'h49; {4'd9, 3'd2}: b = 8'h49;
            {4'd9, 3'd3}: b = 8'h49; {4'd9, 3'd4}: b = 8'h3E;
            {GLYPH_COLON, 3'd2}: b = 8'h14;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: design/led_matrix_clock_frame_generator_top.sv
// ----------------------------------------------------------------------------
// led_matrix_clock_frame_generator_top
// Turns display commands into register-write frames for a chain of LED
// matrix drivers.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one command item: cmd, hours,
// minutes, level, matrix, column, row. Unused command codes are taken and
// dropped without any frame.
// Output channel (out_valid / out_stall) carries one frame item per unstalled
// cycle: broadcast, target, reg_address, reg_data, with last set on the final
// frame of each command.
// The first frame of a command is held in the descriptor queue and then
// loaded into the output register. A command carries 1 (brightness),
// 5 (clear), 6 (test pixel), 10 (init) or 25 (display time or zeros) frames.
// The frame sequencer sets the rate: one frame per cycle unless stalled.
// A two-entry descriptor queue holds the command being streamed and lets one
// more command wait behind it, so commands are taken back to back.
// Reset clears the queue, the sequencer and the output valid; nothing else.
// When out_stall is high the current frame holds and the sequencer pauses;
// the input side stalls only once the queue is full.
// ----------------------------------------------------------------------------
module led_matrix_clock_frame_generator_top
    import lmcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] cmd,
    input  logic [6:0] hours,
    input  logic [6:0] minutes,
    input  logic [7:0] level,
    input  logic [2:0] matrix,
    input  logic [3:0] column,
    input  logic [3:0] row,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       broadcast,
    output logic [2:0] target,
    output logic [3:0] reg_address,
    output logic [7:0] reg_data,
    output logic       last
);

    logic      accept;
    logic      push;
    logic      q_full;
    logic      head_valid;
    logic      pop;
    cmd_desc_t front_desc;
    cmd_desc_t head_desc;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    lmcf_front u_front (
        .valid   (accept),
        .cmd     (cmd),
        .hours   (hours),
        .minutes (minutes),
        .level   (level),
        .matrix  (matrix),
        .column  (column),
        .row     (row),
        .push    (push),
        .desc    (front_desc)
    );

    lmcf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (front_desc),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    lmcf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_desc   (head_desc),
        .pop         (pop),
        .valid       (out_valid),
        .stall       (out_stall),
        .broadcast   (broadcast),
        .target      (target),
        .reg_address (reg_address),
        .reg_data    (reg_data),
        .last        (last)
    );

endmodule

// File: design/lmcf_front.sv
// ----------------------------------------------------------------------------
// lmcf_front
// Decodes one command into a frame descriptor: digit split, clamps, pixel data.
// ----------------------------------------------------------------------------
module lmcf_front
    import lmcf_pkg::*;
(
    input  logic       valid,
    input  logic [2:0] cmd,
    input  logic [6:0] hours,
    input  logic [6:0] minutes,
    input  logic [7:0] level,
    input  logic [2:0] matrix,
    input  logic [3:0] column,
    input  logic [3:0] row,
    output logic       push,
    output cmd_desc_t  desc
);

    logic [6:0]  hrs_sat;
    logic [6:0]  min_sat;
    logic [14:0] hrs_prod;
    logic [14:0] min_prod;
    logic [3:0]  hrs_tens;
    logic [3:0]  min_tens;
    logic [3:0]  hrs_ones;
    logic [3:0]  min_ones;

    assign hrs_sat  = (hours > MAX_VALUE) ? MAX_VALUE : hours;
    assign min_sat  = (minutes > MAX_VALUE) ? MAX_VALUE : minutes;
    assign hrs_prod = 15'(hrs_sat) * 15'd205;
    assign min_prod = 15'(min_sat) * 15'd205;
    assign hrs_tens = hrs_prod[14:11];
    assign min_tens = min_prod[14:11];
    assign hrs_ones = 4'(hrs_sat - 7'(hrs_tens) * 7'd10);
    assign min_ones = 4'(min_sat - 7'(min_tens) * 7'd10);

    always_comb
    begin
        desc        = '0;
        push        = valid;
        desc.level  = (level > MAX_LEVEL) ? 4'(MAX_LEVEL) : level[3:0];
        desc.matrix = matrix;
        desc.column = column;
        desc.pixel  = (row != 4'd0 && row <= 4'd8) ? (8'd1 << (row - 4'd1)) : 8'd0;
        case (cmd)
            CMD_INIT:   desc.op = OP_INIT;
            CMD_BRIGHT: desc.op = OP_BRIGHT;
            CMD_CLEAR:  desc.op = OP_CLEAR;
            CMD_TIME:
            begin
                desc.op    = OP_DIGITS;
                desc.glyph = {min_ones, min_tens, GLYPH_COLON, hrs_ones, hrs_tens};
            end
            CMD_ZEROS:
            begin
                desc.op    = OP_DIGITS;
                desc.glyph = '0;
            end
            CMD_PIXEL:  desc.op = OP_PIXEL;
            default:    push = 1'b0;
        endcase
    end

endmodule

// File: design/lmcf_queue.sv
// ----------------------------------------------------------------------------
// lmcf_queue
// Short descriptor queue between the decode front and the frame sequencer.
// ----------------------------------------------------------------------------
module lmcf_queue
    import lmcf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_desc_t push_desc,
    input  logic      pop,
    output logic      full,
    output logic      head_valid,
    output cmd_desc_t head_desc
);

    cmd_desc_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_desc  = slot_reg[rd_ptr_reg];
    assign count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// File: design/lmcf_back.sv
// ----------------------------------------------------------------------------
// lmcf_back
// Frame sequencer: walks one descriptor, one frame per cycle unless stalled,
// into an output register.
// ----------------------------------------------------------------------------
module lmcf_back
    import lmcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  cmd_desc_t  head_desc,
    output logic       pop,
    output logic       valid,
    input  logic       stall,
    output logic       broadcast,
    output logic [2:0] target,
    output logic [3:0] reg_address,
    output logic [7:0] reg_data,
    output logic       last
);

    logic       valid_reg;
    logic       broadcast_reg;
    logic [2:0] target_reg;
    logic [3:0] address_reg;
    logic [7:0] data_reg;
    logic       last_reg;
    logic [4:0] step_reg;
    logic [4:0] step_next;
    logic [2:0] col_reg;
    logic [2:0] col_next;
    logic [2:0] mat_reg;
    logic [2:0] mat_next;

    logic       adv;
    logic       f_bc;
    logic [2:0] f_target;
    logic [3:0] f_addr;
    logic [7:0] f_data;
    logic       f_last;
    logic [3:0] clear_addr;

    assign adv        = head_valid && (!valid_reg || !stall);
    assign pop        = adv && f_last;
    assign clear_addr = step_reg[3:0] + 4'd1;

    always_comb
    begin
        f_bc     = 1'b1;
        f_target = 3'd0;
        f_addr   = clear_addr;
        f_data   = 8'h00;
        f_last   = 1'b0;
        case (head_desc.op)
            OP_INIT:
            begin
                f_last = (step_reg == 5'd9);
                case (step_reg)
                    5'd0:    f_addr = ADDR_DECODE;
                    5'd1:
                    begin
                        f_addr = ADDR_SCAN;
                        f_data = 8'h04;
                    end
                    5'd2:
                    begin
                        f_addr = ADDR_SHUTDOWN;
                        f_data = 8'h01;
                    end
                    5'd3:    f_addr = ADDR_TEST;
                    5'd4:
                    begin
                        f_addr = ADDR_INTENSITY;
                        f_data = 8'h02;
                    end
                    default: f_addr = step_reg[3:0] - 4'd4;
                endcase
            end
            OP_BRIGHT:
            begin
                f_addr = ADDR_INTENSITY;
                f_data = {4'd0, head_desc.level};
                f_last = 1'b1;
            end
            OP_CLEAR:
            begin
                f_last = (step_reg == 5'd4);
            end
            OP_DIGITS:
            begin
                f_bc     = 1'b0;
                f_target = mat_reg;
                f_addr   = {1'b0, col_reg} + 4'd1;
                f_data   = glyph_byte(head_desc.glyph[mat_reg], col_reg);
                f_last   = (col_reg == LAST_COL) && (mat_reg == LAST_MAT);
            end
            OP_PIXEL:
            begin
                if (step_reg == 5'd5)
                begin
                    f_bc     = 1'b0;
                    f_target = head_desc.matrix;
                    f_addr   = head_desc.column;
                    f_data   = head_desc.pixel;
                    f_last   = 1'b1;
                end
            end
            default:
            begin
                f_last = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        col_next  = col_reg;
        mat_next  = mat_reg;
        if (adv)
        begin
            if (f_last)
            begin
                step_next = '0;
                col_next  = '0;
                mat_next  = '0;
            end
            else
            begin
                step_next = step_reg + 5'd1;
                if (mat_reg == LAST_MAT)
                begin
                    mat_next = '0;
                    col_next = col_reg + 3'd1;
                end
                else
                begin
                    mat_next = mat_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            step_reg  <= '0;
            col_reg   <= '0;
            mat_reg   <= '0;
        end
        else
        begin
            step_reg <= step_next;
            col_reg  <= col_next;
            mat_reg  <= mat_next;
            if (adv)
            begin
                valid_reg <= 1'b1;
            end
            else if (!stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            broadcast_reg <= f_bc;
            target_reg    <= f_target;
            address_reg   <= f_addr;
            data_reg      <= f_data;
            last_reg      <= f_last;
        end
    end

    assign valid       = valid_reg;
    assign broadcast   = broadcast_reg;
    assign target      = target_reg;
    assign reg_address = address_reg;
    assign reg_data    = data_reg;
    assign last        = last_reg;

`ifndef SYNTHESIS
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= MAX_STEP)
        else $error("frame step out of range");

    a_last_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && f_last) |=> (step_reg == 5'd0 && col_reg == 3'd0 && mat_reg == 3'd0))
        else $error("sequencer did not rewind after final frame");

    a_pop_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (valid_reg && last_reg))
        else $error("descriptor released without final frame loaded");
`endif

endmodule
